@@ hdl/pde_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pairwise dispersion energy package
// Shared types, constants, element tables and small helper functions.
// ----------------------------------------------------------------------------
package pde_pkg;

   localparam int PDE_MAX_ELEMENT = 54;
   localparam int PDE_TABLE_SIZE  = 54;
   localparam int PDE_QUEUE_DEPTH = 2;

   localparam logic [63:0] ONE_Q60    = 64'h1000_0000_0000_0000;
   localparam logic [63:0] SIX_Q60    = 64'h6000_0000_0000_0000;
   localparam logic [63:0] LIM47      = 64'h0000_8000_0000_0000;
   localparam logic [63:0] RAD_ROUND  = 64'd50000000;
   localparam logic [63:0] RAD_SCALE  = 64'd100000000;

   // Ceiling of 2^70 / 15625. For a C6 value below 2^30, the product with this
   // constant shifted right by 44 equals floor(c6 * 2^32 / 10^6) exactly.
   localparam logic [63:0] C6_RECIP   = 64'd75557863725914324;

   localparam logic [7:0] K_NONE = 8'd0;
   localparam logic [7:0] K_44   = 8'd44;
   localparam logic [7:0] K_52   = 8'd52;
   localparam logic [7:0] K_60   = 8'd60;
   localparam logic [7:0] K_62   = 8'd62;
   localparam logic [7:0] K_68   = 8'd68;
   localparam logic [7:0] K_72   = 8'd72;
   localparam logic [7:0] K_80   = 8'd80;

   localparam logic [31:0] C6_TABLE [PDE_TABLE_SIZE] = '{
      32'd2428335, 32'd1387620, 32'd27925857, 32'd27925857, 32'd54290641, 32'd30354192,
      32'd21334661, 32'd12141677, 32'd13008940, 32'd10927509, 32'd99041393, 32'd99041393,
      32'd187155277, 32'd160096682, 32'd135986781, 32'd96613058, 32'd87940431,
      32'd79961615, 32'd187328729, 32'd187328729, 32'd187328729, 32'd187328729,
      32'd187328729, 32'd187328729, 32'd187328729, 32'd187328729, 32'd187328729,
      32'd187328729, 32'd187328729, 32'd187328729, 32'd294695843, 32'd296603821,
      32'd283941787, 32'd219243994, 32'd216295301, 32'd208316485, 32'd427907384,
      32'd427907384, 32'd427907384, 32'd427907384, 32'd427907384, 32'd427907384,
      32'd427907384, 32'd427907384, 32'd427907384, 32'd427907384, 32'd427907384,
      32'd427907384, 32'd647324831, 32'd671434732, 32'd666751514, 32'd550538321,
      32'd546375460, 32'd520184128
   };

   localparam logic [31:0] RADIUS_TABLE [PDE_TABLE_SIZE] = '{
      32'd189161571, 32'd191240270, 32'd155902394, 32'd266073419, 32'd280624309,
      32'd274388214, 32'd263994721, 32'd253601228, 32'd243207735, 32'd234892940,
      32'd216184653, 32'd257758625, 32'd309726090, 32'd324276980, 32'd322198281,
      32'd318040884, 32'd309726090, 32'd301411295, 32'd280624309, 32'd278545611,
      32'd295175199, 32'd295175199, 32'd295175199, 32'd295175199, 32'd295175199,
      32'd295175199, 32'd295175199, 32'd295175199, 32'd295175199, 32'd295175199,
      32'd311804788, 32'd326355678, 32'd332591774, 32'd334670473, 32'd330513075,
      32'd326355678, 32'd307647391, 32'd303489994, 32'd309726090, 32'd309726090,
      32'd309726090, 32'd309726090, 32'd309726090, 32'd309726090, 32'd309726090,
      32'd309726090, 32'd309726090, 32'd309726090, 32'd315962185, 32'd340906568,
      32'd355457459, 32'd357536157, 32'd357536157, 32'd355457459
   };

   typedef logic [63:0] radius_table_type [PDE_TABLE_SIZE];

   function automatic radius_table_type make_radius_q28();
      radius_table_type t;
      for (int i = 0; i < PDE_TABLE_SIZE; i++) begin
         t[i] = ((64'(RADIUS_TABLE[i]) << 28) + RAD_ROUND) / RAD_SCALE;
      end
      return t;
   endfunction

   localparam radius_table_type RADIUS_Q28_TABLE = make_radius_q28();

   typedef enum logic [1:0] {
      ALU_MUL  = 2'd0,
      ALU_DIV  = 2'd1,
      ALU_SQRT = 2'd2
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
      logic [63:0] a;
      logic [63:0] b;
      logic [7:0]  k;
   } alu_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] result;
   } alu_rsp_type;

   typedef enum logic [1:0] {
      CLS_COMPUTE    = 2'd0,
      CLS_BAD        = 2'd1,
      CLS_COINCIDENT = 2'd2
   } pair_class_type;

   typedef struct packed {
      pair_class_type   cls;
      logic [5:0]       za;
      logic [5:0]       zb;
      logic [2:0][31:0] mag;
      logic [2:0]       neg;
      logic             last;
   } pair_entry_type;

   function automatic logic [31:0] c6_value(input logic [5:0] z);
      logic [31:0] v;
      v = '0;
      if (z != 6'd0 && 32'(z) <= PDE_TABLE_SIZE) begin
         v = C6_TABLE[z - 6'd1];
      end
      return v;
   endfunction

   function automatic logic [63:0] radius_q28(input logic [5:0] z);
      logic [63:0] v;
      v = '0;
      if (z != 6'd0 && 32'(z) <= PDE_TABLE_SIZE) begin
         v = RADIUS_Q28_TABLE[z - 6'd1];
      end
      return v;
   endfunction

   function automatic logic signed [47:0] sat48(input logic [63:0] mag, input logic negative);
      logic signed [47:0] v;
      if (mag >= LIM47) begin
         v = negative ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
      end else begin
         v = negative ? -$signed(mag[47:0]) : $signed(mag[47:0]);
      end
      return v;
   endfunction

endpackage

@@ hdl/pde_channels.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pairwise dispersion energy channels
// Valid/ready interfaces for the pair requests and the pair results.
// ----------------------------------------------------------------------------
interface pde_req_if;
   logic               valid;
   logic               ready;
   logic [5:0]         element_a;
   logic [5:0]         element_b;
   logic signed [31:0] delta_x;
   logic signed [31:0] delta_y;
   logic signed [31:0] delta_z;
   logic               last_pair;

   modport source (output valid, element_a, element_b, delta_x, delta_y, delta_z,
                   last_pair, input ready);
   modport sink (input valid, element_a, element_b, delta_x, delta_y, delta_z,
                 last_pair, output ready);
endinterface

interface pde_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [47:0] grad_x;
   logic signed [47:0] grad_y;
   logic signed [47:0] grad_z;
   logic signed [47:0] total_energy;
   logic               energy_final;
   logic               status;

   modport source (output valid, grad_x, grad_y, grad_z, total_energy, energy_final,
                   status, input ready);
   modport sink (input valid, grad_x, grad_y, grad_z, total_energy, energy_final,
                 status, output ready);
endinterface

@@ hdl/pde_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pairwise dispersion energy front end
// Accepts pair transfers and classifies them as valid, bad element or
// coincident, with the axis magnitudes and signs split out.
// ----------------------------------------------------------------------------
module pde_front (
   pde_req_if.sink                  req_chan,
   input  logic                     queue_full,
   output logic                     push,
   output pde_pkg::pair_entry_type  entry
);

   logic [2:0][31:0] delta;
   logic [2:0]       bad;

   assign delta = {req_chan.delta_z, req_chan.delta_y, req_chan.delta_x};
   assign req_chan.ready = !queue_full;
   assign push = req_chan.valid && !queue_full;

   assign bad[0] = (req_chan.element_a == 6'd0) ||
                   (32'(req_chan.element_a) > pde_pkg::PDE_MAX_ELEMENT);
   assign bad[1] = (req_chan.element_b == 6'd0) ||
                   (32'(req_chan.element_b) > pde_pkg::PDE_MAX_ELEMENT);
   assign bad[2] = 1'b0;

   always_comb begin
      entry.za   = req_chan.element_a;
      entry.zb   = req_chan.element_b;
      entry.last = req_chan.last_pair;
      for (int i = 0; i < 3; i++) begin
         entry.neg[i] = delta[i][31];
         entry.mag[i] = delta[i][31] ? (~delta[i] + 32'd1) : delta[i];
      end
      if (|bad) begin
         entry.cls = pde_pkg::CLS_BAD;
      end else if (delta == '0) begin
         entry.cls = pde_pkg::CLS_COINCIDENT;
      end else begin
         entry.cls = pde_pkg::CLS_COMPUTE;
      end
   end

endmodule

@@ hdl/pde_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pairwise dispersion energy queue
// Short first-in first-out queue of classified pairs between front and back.
// ----------------------------------------------------------------------------
module pde_fifo #(
   parameter int DEPTH = pde_pkg::PDE_QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  pde_pkg::pair_entry_type push_entry,
   input  logic                    pop,
   output pde_pkg::pair_entry_type head,
   output logic                    full,
   output logic                    empty
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   pde_pkg::pair_entry_type entries_ff [DEPTH];
   logic [IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ hdl/pde_alu.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pairwise dispersion energy arithmetic unit
// Shared iterative unit: 64x64 multiply with shift and saturation from four
// 32x32 products, bit-serial scaled division and bit-serial square root.
// ----------------------------------------------------------------------------
module pde_alu (
   input  logic                 clock,
   input  logic                 reset,
   input  pde_pkg::alu_req_type req,
   output pde_pkg::alu_rsp_type rsp
);

   typedef enum logic [4:0] {
      AS_IDLE   = 5'b00001,
      AS_MUL    = 5'b00010,
      AS_MULFIN = 5'b00100,
      AS_DIV    = 5'b01000,
      AS_SQRT   = 5'b10000
   } alu_state_type;

   alu_state_type state_ff, state_in;
   logic [63:0]  a_ff, a_in;
   logic [63:0]  b_ff, b_in;
   logic [7:0]   k_ff, k_in;
   logic [7:0]   cnt_ff, cnt_in;
   logic [63:0]  rem_ff, rem_in;
   logic [63:0]  q_ff, q_in;
   logic         sat_ff, sat_in;
   logic [127:0] acc_ff, acc_in;
   logic [63:0]  pp_ff, pp_in;
   logic [1:0]   psh_ff, psh_in;
   logic         done_ff, done_in;
   logic [63:0]  result_ff, result_in;

   logic [31:0]  a_half, b_half;
   logic [127:0] pp_wide, shifted;
   logic [64:0]  rem_wide;
   logic         div_ge, sat_nx;
   logic [63:0]  q_nx, trial;

   assign rsp.done   = done_ff;
   assign rsp.result = result_ff;

   always_comb begin
      a_half   = cnt_ff[1] ? a_ff[63:32] : a_ff[31:0];
      b_half   = cnt_ff[0] ? b_ff[63:32] : b_ff[31:0];
      case (psh_ff)
         2'd0:    pp_wide = {64'b0, pp_ff};
         2'd1:    pp_wide = {32'b0, pp_ff, 32'b0};
         default: pp_wide = {pp_ff, 64'b0};
      endcase
      shifted  = acc_ff >> k_ff;
      rem_wide = {rem_ff, a_ff[63]};
      div_ge   = rem_wide >= {1'b0, b_ff};
      sat_nx   = sat_ff | q_ff[63];
      trial    = q_ff + b_ff;
   end

   always_comb begin
      state_in  = state_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      k_in      = k_ff;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      q_in      = q_ff;
      sat_in    = sat_ff;
      acc_in    = acc_ff;
      pp_in     = pp_ff;
      psh_in    = psh_ff;
      done_in   = 1'b0;
      result_in = result_ff;
      q_nx      = q_ff;
      case (state_ff)
         AS_IDLE: begin
            if (req.start) begin
               a_in   = req.a;
               b_in   = req.b;
               k_in   = req.k;
               cnt_in = '0;
               acc_in = '0;
               rem_in = '0;
               q_in   = '0;
               sat_in = 1'b0;
               case (req.op)
                  pde_pkg::ALU_MUL: begin
                     state_in = AS_MUL;
                  end
                  pde_pkg::ALU_DIV: begin
                     if (req.b == '0) begin
                        result_in = '1;
                        done_in   = 1'b1;
                     end else begin
                        cnt_in   = 8'd64 + req.k;
                        state_in = AS_DIV;
                     end
                  end
                  pde_pkg::ALU_SQRT: begin
                     rem_in   = req.a;
                     b_in     = 64'h4000_0000_0000_0000;
                     cnt_in   = 8'd32;
                     state_in = AS_SQRT;
                  end
                  default: begin
                     result_in = '0;
                     done_in   = 1'b1;
                  end
               endcase
            end
         end
         AS_MUL: begin
            if (cnt_ff != 8'd4) begin
               pp_in  = a_half * b_half;
               psh_in = {1'b0, cnt_ff[1]} + {1'b0, cnt_ff[0]};
            end
            if (cnt_ff != 8'd0) begin
               acc_in = acc_ff + pp_wide;
            end
            if (cnt_ff == 8'd4) begin
               state_in = AS_MULFIN;
            end else begin
               cnt_in = cnt_ff + 8'd1;
            end
         end
         AS_MULFIN: begin
            result_in = (|shifted[127:64]) ? '1 : shifted[63:0];
            done_in   = 1'b1;
            state_in  = AS_IDLE;
         end
         AS_DIV: begin
            q_nx   = {q_ff[62:0], div_ge};
            a_in   = {a_ff[62:0], 1'b0};
            sat_in = sat_nx;
            q_in   = q_nx;
            rem_in = div_ge ? 64'(rem_wide - {1'b0, b_ff}) : rem_wide[63:0];
            cnt_in = cnt_ff - 8'd1;
            if (cnt_ff == 8'd1) begin
               result_in = sat_nx ? '1 : q_nx;
               done_in   = 1'b1;
               state_in  = AS_IDLE;
            end
         end
         AS_SQRT: begin
            if (rem_ff >= trial) begin
               rem_in = rem_ff - trial;
               q_nx   = (q_ff >> 1) + b_ff;
            end else begin
               q_nx   = q_ff >> 1;
            end
            q_in   = q_nx;
            b_in   = b_ff >> 2;
            cnt_in = cnt_ff - 8'd1;
            if (cnt_ff == 8'd1) begin
               result_in = q_nx;
               done_in   = 1'b1;
               state_in  = AS_IDLE;
            end
         end
         default: begin
            state_in = AS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= AS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff      <= a_in;
      b_ff      <= b_in;
      k_ff      <= k_in;
      cnt_ff    <= cnt_in;
      rem_ff    <= rem_in;
      q_ff      <= q_in;
      sat_ff    <= sat_in;
      acc_ff    <= acc_in;
      pp_ff     <= pp_in;
      psh_ff    <= psh_in;
      result_ff <= result_in;
   end

endmodule

@@ hdl/pde_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pairwise dispersion energy back end
// Sequences one pair through the shared arithmetic unit, keeps the running
// energy and error flag, and holds the result register.
// ----------------------------------------------------------------------------
module pde_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_enable,
   input  logic                    csr_write_data,
   input  pde_pkg::pair_entry_type head,
   input  logic                    head_empty,
   output logic                    pop,
   output pde_pkg::alu_req_type    alu_req,
   input  pde_pkg::alu_rsp_type    alu_rsp,
   pde_rsp_if.source               rsp_chan
);

   typedef enum logic [22:0] {
      ST_IDLE = 23'd1 << 0,
      ST_SQ   = 23'd1 << 1,
      ST_A2   = 23'd1 << 2,
      ST_C6M  = 23'd1 << 3,
      ST_C6S  = 23'd1 << 4,
      ST_C6Q  = 23'd1 << 5,
      ST_A4   = 23'd1 << 6,
      ST_A6   = 23'd1 << 7,
      ST_P    = 23'd1 << 8,
      ST_R    = 23'd1 << 9,
      ST_R2   = 23'd1 << 10,
      ST_X    = 23'd1 << 11,
      ST_X2   = 23'd1 << 12,
      ST_H    = 23'd1 << 13,
      ST_Q1A  = 23'd1 << 14,
      ST_Q1   = 23'd1 << 15,
      ST_Q2   = 23'd1 << 16,
      ST_K    = 23'd1 << 17,
      ST_E    = 23'd1 << 18,
      ST_M    = 23'd1 << 19,
      ST_D    = 23'd1 << 20,
      ST_G    = 23'd1 << 21,
      ST_OUT  = 23'd1 << 22
   } back_state_type;

   back_state_type state_ff, state_in;
   logic [1:0]  axis_ff, axis_in;
   logic        busy_ff, busy_in;
   logic        near_ff, near_in;
   logic [63:0] s_ff, s_in;
   logic [63:0] r0_ff, r0_in;
   logic [63:0] a2_ff, a2_in;
   logic [63:0] t_ff, t_in;
   logic [63:0] u_ff, u_in;
   logic [63:0] p_ff, p_in;
   logic [63:0] r_ff, r_in;
   logic [63:0] r2_ff, r2_in;
   logic [63:0] x_ff, x_in;
   logic [63:0] x2_ff, x2_in;
   logic [63:0] h_ff, h_in;
   logic [63:0] k_ff, k_in;
   logic [63:0] e_ff, e_in;
   logic [63:0] m_ff, m_in;
   logic signed [2:0][47:0] g_ff, g_in;
   logic signed [47:0] energy_sum_ff, energy_sum_in;
   logic        range_error_ff, range_error_in;
   logic        grad_en_ff, grad_en_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic signed [2:0][47:0] rsp_grad_ff, rsp_grad_in;
   logic signed [47:0] rsp_energy_ff, rsp_energy_in;
   logic        rsp_final_ff, rsp_final_in;
   logic        rsp_status_ff, rsp_status_in;

   logic        op_state, near_c, out_free, k_neg;
   logic [31:0] cur_mag;
   logic [63:0] six_x2, den, num, m6, e_clip;
   logic [48:0] diff;
   logic signed [47:0] energy_next;
   logic        error_next;

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.grad_x       = rsp_grad_ff[0];
   assign rsp_chan.grad_y       = rsp_grad_ff[1];
   assign rsp_chan.grad_z       = rsp_grad_ff[2];
   assign rsp_chan.total_energy = rsp_energy_ff;
   assign rsp_chan.energy_final = rsp_final_ff;
   assign rsp_chan.status       = rsp_status_ff;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign cur_mag  = head.mag[axis_ff];
   assign near_c   = s_ff <= (a2_ff >> 8);

   always_comb begin
      six_x2 = (x2_ff << 2) + (x2_ff << 1);
      m6     = (m_ff << 2) + (m_ff << 1);
      k_neg  = 1'b0;
      if (near_ff) begin
         den = x2_ff + pde_pkg::SIX_Q60;
         num = pde_pkg::SIX_Q60 - x2_ff;
      end else begin
         den = pde_pkg::ONE_Q60 + six_x2;
         if (six_x2 >= pde_pkg::ONE_Q60) begin
            num = six_x2 - pde_pkg::ONE_Q60;
         end else begin
            num   = pde_pkg::ONE_Q60 - six_x2;
            k_neg = 1'b1;
         end
      end
   end

   always_comb begin
      e_clip = (e_ff > pde_pkg::LIM47) ? pde_pkg::LIM47 : e_ff;
      diff   = {energy_sum_ff[47], energy_sum_ff} - {1'b0, e_clip[47:0]};
      energy_next = energy_sum_ff;
      error_next  = range_error_ff;
      case (head.cls)
         pde_pkg::CLS_COMPUTE: begin
            energy_next = (diff[48] && !diff[47]) ? 48'sh8000_0000_0000 : diff[47:0];
         end
         pde_pkg::CLS_BAD: begin
            error_next = 1'b1;
         end
         default: begin
            energy_next = energy_sum_ff;
         end
      endcase
   end

   always_comb begin
      alu_req.op = pde_pkg::ALU_MUL;
      alu_req.a  = '0;
      alu_req.b  = '0;
      alu_req.k  = pde_pkg::K_NONE;
      op_state   = 1'b1;
      case (state_ff)
         ST_SQ: begin
            alu_req.a = 64'(cur_mag);
            alu_req.b = 64'(cur_mag);
         end
         ST_A2: begin
            alu_req.a = r0_ff;
            alu_req.b = r0_ff;
         end
         ST_C6M: begin
            alu_req.a = 64'(pde_pkg::c6_value(head.za));
            alu_req.b = 64'(pde_pkg::c6_value(head.zb));
         end
         ST_C6S: begin
            alu_req.op = pde_pkg::ALU_SQRT;
            alu_req.a  = t_ff;
         end
         ST_C6Q: begin
            alu_req.a = t_ff;
            alu_req.b = pde_pkg::C6_RECIP;
            alu_req.k = pde_pkg::K_44;
         end
         ST_A4: begin
            alu_req.a = a2_ff;
            alu_req.b = a2_ff;
            alu_req.k = pde_pkg::K_62;
         end
         ST_A6: begin
            alu_req.a = t_ff;
            alu_req.b = a2_ff;
            alu_req.k = pde_pkg::K_62;
         end
         ST_P: begin
            alu_req.op = pde_pkg::ALU_DIV;
            alu_req.a  = u_ff;
            alu_req.b  = t_ff;
            alu_req.k  = pde_pkg::K_72;
         end
         ST_R: begin
            alu_req.op = pde_pkg::ALU_DIV;
            alu_req.a  = near_c ? s_ff : a2_ff;
            alu_req.b  = near_c ? a2_ff : s_ff;
            alu_req.k  = near_c ? pde_pkg::K_68 : pde_pkg::K_52;
         end
         ST_R2: begin
            alu_req.a = r_ff;
            alu_req.b = r_ff;
            alu_req.k = pde_pkg::K_60;
         end
         ST_X: begin
            alu_req.a = r2_ff;
            alu_req.b = r_ff;
            alu_req.k = pde_pkg::K_60;
         end
         ST_X2: begin
            alu_req.a = x_ff;
            alu_req.b = x_ff;
            alu_req.k = pde_pkg::K_60;
         end
         ST_H: begin
            alu_req.op = pde_pkg::ALU_DIV;
            alu_req.a  = x_ff;
            alu_req.b  = den;
            alu_req.k  = pde_pkg::K_60;
         end
         ST_Q1A: begin
            alu_req.a = r2_ff;
            alu_req.b = r2_ff;
            alu_req.k = pde_pkg::K_60;
         end
         ST_Q1: begin
            alu_req.op = pde_pkg::ALU_DIV;
            alu_req.a  = near_ff ? r2_ff : t_ff;
            alu_req.b  = den;
            alu_req.k  = pde_pkg::K_60;
         end
         ST_Q2: begin
            alu_req.a = t_ff;
            alu_req.b = num;
            alu_req.k = pde_pkg::K_60;
         end
         ST_K: begin
            alu_req.op = pde_pkg::ALU_DIV;
            alu_req.a  = t_ff;
            alu_req.b  = den;
            alu_req.k  = pde_pkg::K_60;
         end
         ST_E: begin
            alu_req.a = p_ff;
            alu_req.b = h_ff;
            alu_req.k = pde_pkg::K_80;
         end
         ST_M: begin
            alu_req.a = p_ff;
            alu_req.b = k_ff;
            alu_req.k = pde_pkg::K_60;
         end
         ST_D: begin
            alu_req.op = pde_pkg::ALU_DIV;
            alu_req.a  = 64'(cur_mag);
            alu_req.b  = a2_ff;
            alu_req.k  = pde_pkg::K_80;
         end
         ST_G: begin
            alu_req.a = m6;
            alu_req.b = t_ff;
            alu_req.k = pde_pkg::K_68;
         end
         default: begin
            op_state = 1'b0;
         end
      endcase
      alu_req.start = op_state && !busy_ff;
   end

   always_comb begin
      state_in       = state_ff;
      axis_in        = axis_ff;
      busy_in        = busy_ff;
      near_in        = near_ff;
      s_in           = s_ff;
      r0_in          = r0_ff;
      a2_in          = a2_ff;
      t_in           = t_ff;
      u_in           = u_ff;
      p_in           = p_ff;
      r_in           = r_ff;
      r2_in          = r2_ff;
      x_in           = x_ff;
      x2_in          = x2_ff;
      h_in           = h_ff;
      k_in           = k_ff;
      e_in           = e_ff;
      m_in           = m_ff;
      g_in           = g_ff;
      energy_sum_in  = energy_sum_ff;
      range_error_in = range_error_ff;
      grad_en_in     = csr_write_enable ? csr_write_data : grad_en_ff;
      rsp_valid_in   = rsp_chan.ready ? 1'b0 : rsp_valid_ff;
      rsp_grad_in    = rsp_grad_ff;
      rsp_energy_in  = rsp_energy_ff;
      rsp_final_in   = rsp_final_ff;
      rsp_status_in  = rsp_status_ff;
      pop            = 1'b0;

      if (alu_req.start) begin
         busy_in = 1'b1;
      end else if (alu_rsp.done) begin
         busy_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (!head_empty) begin
               g_in    = '0;
               axis_in = '0;
               r0_in   = pde_pkg::radius_q28(head.za) + pde_pkg::radius_q28(head.zb);
               state_in = (head.cls == pde_pkg::CLS_COMPUTE) ? ST_SQ : ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_grad_in    = g_ff;
               rsp_energy_in  = energy_next;
               rsp_final_in   = head.last;
               rsp_status_in  = error_next;
               energy_sum_in  = head.last ? '0 : energy_next;
               range_error_in = head.last ? 1'b0 : error_next;
               pop            = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            if (alu_rsp.done) begin
               case (state_ff)
                  ST_SQ: begin
                     s_in = ((axis_ff == 2'd0) ? 64'd0 : s_ff) + alu_rsp.result;
                     if (axis_ff == 2'd2) begin
                        axis_in  = '0;
                        state_in = ST_A2;
                     end else begin
                        axis_in = axis_ff + 2'd1;
                     end
                  end
                  ST_A2: begin
                     a2_in    = alu_rsp.result;
                     state_in = ST_C6M;
                  end
                  ST_C6M: begin
                     t_in     = alu_rsp.result;
                     state_in = ST_C6S;
                  end
                  ST_C6S: begin
                     t_in     = alu_rsp.result;
                     state_in = ST_C6Q;
                  end
                  ST_C6Q: begin
                     u_in     = alu_rsp.result;
                     state_in = ST_A4;
                  end
                  ST_A4: begin
                     t_in     = alu_rsp.result;
                     state_in = ST_A6;
                  end
                  ST_A6: begin
                     t_in     = alu_rsp.result;
                     state_in = ST_P;
                  end
                  ST_P: begin
                     p_in     = alu_rsp.result;
                     state_in = ST_R;
                  end
                  ST_R: begin
                     r_in     = alu_rsp.result;
                     near_in  = near_c;
                     state_in = ST_R2;
                  end
                  ST_R2: begin
                     r2_in    = alu_rsp.result;
                     state_in = ST_X;
                  end
                  ST_X: begin
                     x_in     = alu_rsp.result;
                     state_in = ST_X2;
                  end
                  ST_X2: begin
                     x2_in    = alu_rsp.result;
                     state_in = ST_H;
                  end
                  ST_H: begin
                     h_in     = alu_rsp.result;
                     state_in = near_ff ? ST_Q1 : ST_Q1A;
                  end
                  ST_Q1A: begin
                     t_in     = alu_rsp.result;
                     state_in = ST_Q1;
                  end
                  ST_Q1: begin
                     t_in     = alu_rsp.result;
                     state_in = ST_Q2;
                  end
                  ST_Q2: begin
                     t_in     = alu_rsp.result;
                     state_in = ST_K;
                  end
                  ST_K: begin
                     k_in     = alu_rsp.result;
                     state_in = ST_E;
                  end
                  ST_E: begin
                     e_in     = alu_rsp.result;
                     state_in = grad_en_ff ? ST_M : ST_OUT;
                  end
                  ST_M: begin
                     m_in     = alu_rsp.result;
                     axis_in  = '0;
                     state_in = ST_D;
                  end
                  ST_D: begin
                     t_in     = alu_rsp.result;
                     state_in = ST_G;
                  end
                  ST_G: begin
                     g_in[axis_ff] = pde_pkg::sat48(alu_rsp.result,
                                                    k_neg == head.neg[axis_ff]);
                     if (axis_ff == 2'd2) begin
                        axis_in  = '0;
                        state_in = ST_OUT;
                     end else begin
                        axis_in  = axis_ff + 2'd1;
                        state_in = ST_D;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         axis_ff        <= '0;
         busy_ff        <= 1'b0;
         energy_sum_ff  <= '0;
         range_error_ff <= 1'b0;
         grad_en_ff     <= 1'b1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         axis_ff        <= axis_in;
         busy_ff        <= busy_in;
         energy_sum_ff  <= energy_sum_in;
         range_error_ff <= range_error_in;
         grad_en_ff     <= grad_en_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      near_ff       <= near_in;
      s_ff          <= s_in;
      r0_ff         <= r0_in;
      a2_ff         <= a2_in;
      t_ff          <= t_in;
      u_ff          <= u_in;
      p_ff          <= p_in;
      r_ff          <= r_in;
      r2_ff         <= r2_in;
      x_ff          <= x_in;
      x2_ff         <= x2_in;
      h_ff          <= h_in;
      k_ff          <= k_in;
      e_ff          <= e_in;
      m_ff          <= m_in;
      g_ff          <= g_in;
      rsp_grad_ff   <= rsp_grad_in;
      rsp_energy_ff <= rsp_energy_in;
      rsp_final_ff  <= rsp_final_in;
      rsp_status_ff <= rsp_status_in;
   end

   // A result from the arithmetic unit always answers an operation it was given.
   assert property (@(posedge clock) disable iff (reset) alu_rsp.done |-> busy_ff)
      else $error("arithmetic result without an operation in flight");

   // Popping a pair always loads the result register.
   assert property (@(posedge clock) disable iff (reset) pop |=> rsp_valid_ff)
      else $error("pair popped without a result being loaded");

   // The running dispersion energy is never positive.
   assert property (@(posedge clock) disable iff (reset)
                    energy_sum_ff[47] || (energy_sum_ff == '0))
      else $error("running energy became positive");

   // A waiting pair is always picked up from idle.
   assert property (@(posedge clock) disable iff (reset)
                    (state_ff == ST_IDLE) && !head_empty |=> (state_ff != ST_IDLE))
      else $error("queued pair not started");

endmodule

@@ hdl/pairwise_dispersion_energy_core.sv @@
`timescale 1ns / 1ps
// A valid pair takes longer with gradients on than with gradients off; the time is set
// mostly by the bit-serial divider of the shared unit.
// A pair with a bad element or coincident atoms skips the arithmetic and goes straight to the output.
// Throughput: one pair at a time in the back end; the queue takes new transfers meanwhile while it has room.
// Reset is synchronous and active high; it clears the energy, the error flag and
// the queue, and sets gradient_enable to 1.
// ----------------------------------------------------------------------------
// Pairwise dispersion energy core
// Damped C6/R^6 dispersion energy and pair gradient, accumulated per molecule.
// ----------------------------------------------------------------------------
module pairwise_dispersion_energy_core #(
   parameter int QUEUE_DEPTH = pde_pkg::PDE_QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      csr_write_enable,
   input  logic      csr_write_data,
   pde_req_if.sink   req_chan,
   pde_rsp_if.source rsp_chan
);

   pde_pkg::pair_entry_type push_entry, head;
   pde_pkg::alu_req_type    alu_req;
   pde_pkg::alu_rsp_type    alu_rsp;
   logic push, pop, full, empty;

   pde_front u_front (
      .req_chan   (req_chan),
      .queue_full (full),
      .push       (push),
      .entry      (push_entry)
   );

   pde_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .full       (full),
      .empty      (empty)
   );

   pde_alu u_alu (
      .clock (clock),
      .reset (reset),
      .req   (alu_req),
      .rsp   (alu_rsp)
   );

   pde_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .head             (head),
      .head_empty       (empty),
      .pop              (pop),
      .alu_req          (alu_req),
      .alu_rsp          (alu_rsp),
      .rsp_chan         (rsp_chan)
   );

endmodule

@@ test/pde_pair_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pairwise dispersion energy checker
// Watches the pair and result channels and the control register port. Each
// accepted pair is run through a bit-exact fixed-point model of the damped
// dispersion term. The predicted result is queued and compared field by field
// with the next accepted result. The failure count and the number of results
// still owed go back to the testbench top.
// ----------------------------------------------------------------------------
module pde_pair_checker (
   input  logic      clock,
   input  logic      reset,
   input  logic      csr_write_enable,
   input  logic      csr_write_data,
   pde_req_if        req_mon,
   pde_rsp_if        rsp_mon,
   output int        fail_count,
   output int        owed_count,
   output int        result_count
);

   typedef struct packed {
      logic signed [47:0] grad_x;
      logic signed [47:0] grad_y;
      logic signed [47:0] grad_z;
      logic signed [47:0] total_energy;
      logic               energy_final;
      logic               status;
   } pair_result_type;

   pair_result_type expected_results[$];
   longint       molecule_energy;
   logic         element_error;
   logic         grad_on;

   function automatic logic [63:0] mul_q(input logic [63:0] a, input logic [63:0] b,
                                         input int k);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      p = p >> k;
      return (p[127:64] != 0) ? '1 : p[63:0];
   endfunction

   function automatic logic [63:0] div_q(input logic [63:0] n, input int k,
                                         input logic [63:0] d);
      logic [191:0] num;
      logic [191:0] q;
      if (d == 0) return '1;
      num = {128'd0, n} << k;
      q = num / {128'd0, d};
      return (q[191:64] != 0) ? '1 : q[63:0];
   endfunction

   function automatic logic [63:0] root_floor(input logic [63:0] v);
      logic [63:0] res;
      logic [63:0] b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic logic [63:0] radius_fixed(input logic [5:0] z);
      logic [63:0] r;
      r = pde_pkg::RADIUS_TABLE[z - 6'd1];
      return ((r << 28) + 64'd50000000) / 64'd100000000;
   endfunction

   function automatic logic signed [47:0] clamp_grad(input logic [63:0] m,
                                                     input logic negative);
      if (m >= 64'h0000_8000_0000_0000)
         return negative ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
      return negative ? -$signed(m[47:0]) : $signed(m[47:0]);
   endfunction

   function automatic pair_result_type predict_pair(input logic [5:0] za,
                                                    input logic [5:0] zb,
                                                    input logic signed [31:0] dv[3],
                                                    input logic last);
      pair_result_type res;
      logic [63:0] mag[3];
      logic        neg[3];
      logic [63:0] s, r0, a2, a4, a6, c6u, c6q, p, r, r2, x, x2, den, h, q1, q2, k;
      logic [63:0] six, num, e, d, m6;
      logic        k_neg;
      longint      ns;
      res.grad_x = 0;
      res.grad_y = 0;
      res.grad_z = 0;
      s = 0;
      k_neg = 0;
      for (int i = 0; i < 3; i++) begin
         neg[i] = dv[i][31];
         mag[i] = neg[i] ? {32'd0, -dv[i]} : {32'd0, dv[i]};
         s = s + mag[i] * mag[i];
      end
      if (za < 1 || za > pde_pkg::PDE_MAX_ELEMENT || zb < 1 ||
          zb > pde_pkg::PDE_MAX_ELEMENT) begin
         element_error = 1;
      end else if (s != 0) begin
         r0 = radius_fixed(za) + radius_fixed(zb);
         a2 = r0 * r0;
         a4 = mul_q(a2, a2, 62);
         a6 = mul_q(a4, a2, 62);
         c6u = root_floor(64'(pde_pkg::C6_TABLE[za - 6'd1]) *
                          64'(pde_pkg::C6_TABLE[zb - 6'd1]));
         c6q = (c6u << 32) / 64'd1000000;
         p = div_q(c6q, 72, a6);
         if (s <= (a2 >> 8)) begin
            r = div_q(s, 68, a2);
            r2 = mul_q(r, r, 60);
            x = mul_q(r2, r, 60);
            x2 = mul_q(x, x, 60);
            den = x2 + pde_pkg::SIX_Q60;
            h = div_q(x, 60, den);
            q1 = div_q(r2, 60, den);
            q2 = mul_q(q1, pde_pkg::SIX_Q60 - x2, 60);
         end else begin
            r = div_q(a2, 52, s);
            r2 = mul_q(r, r, 60);
            x = mul_q(r2, r, 60);
            x2 = mul_q(x, x, 60);
            six = 64'd6 * x2;
            den = pde_pkg::ONE_Q60 + six;
            h = div_q(x, 60, den);
            if (six >= pde_pkg::ONE_Q60) begin
               num = six - pde_pkg::ONE_Q60;
            end else begin
               num = pde_pkg::ONE_Q60 - six;
               k_neg = 1;
            end
            q1 = div_q(mul_q(r2, r2, 60), 60, den);
            q2 = mul_q(q1, num, 60);
         end
         k = div_q(q2, 60, den);
         if (grad_on) begin
            m6 = 64'd6 * mul_q(p, k, 60);
            d = div_q(mag[0], 80, a2);
            res.grad_x = clamp_grad(mul_q(m6, d, 68), k_neg == neg[0]);
            d = div_q(mag[1], 80, a2);
            res.grad_y = clamp_grad(mul_q(m6, d, 68), k_neg == neg[1]);
            d = div_q(mag[2], 80, a2);
            res.grad_z = clamp_grad(mul_q(m6, d, 68), k_neg == neg[2]);
         end
         e = mul_q(p, h, 80);
         if (e > pde_pkg::LIM47) e = pde_pkg::LIM47;
         ns = molecule_energy - longint'(e);
         if (ns < -longint'(pde_pkg::LIM47)) ns = -longint'(pde_pkg::LIM47);
         molecule_energy = ns;
      end
      res.total_energy = molecule_energy[47:0];
      res.energy_final = last;
      res.status = element_error;
      if (last) begin
         molecule_energy = 0;
         element_error = 0;
      end
      return res;
   endfunction

   assign owed_count = expected_results.size();

   always @(posedge clock) begin
      pair_result_type got;
      pair_result_type want;
      logic signed [31:0] dv[3];
      if (reset) begin
         expected_results.delete();
         molecule_energy = 0;
         element_error = 0;
         grad_on = 1;
         fail_count = 0;
         result_count = 0;
      end else begin
         if (csr_write_enable) grad_on = csr_write_data;
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.grad_x = rsp_mon.grad_x;
            got.grad_y = rsp_mon.grad_y;
            got.grad_z = rsp_mon.grad_z;
            got.total_energy = rsp_mon.total_energy;
            got.energy_final = rsp_mon.energy_final;
            got.status = rsp_mon.status;
            result_count++;
            if (expected_results.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("ERROR: unexpected result transfer at %0t", $realtime);
            end else begin
               want = expected_results.pop_front();
               if (got != want) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("ERROR: result %0d mismatch: expected g=(%0d %0d %0d) E=%0d fin=%0b st=%0b",
                              result_count, want.grad_x, want.grad_y, want.grad_z,
                              want.total_energy, want.energy_final, want.status);
                     $display("       got g=(%0d %0d %0d) E=%0d fin=%0b st=%0b",
                              got.grad_x, got.grad_y, got.grad_z, got.total_energy,
                              got.energy_final, got.status);
                  end
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            dv[0] = req_mon.delta_x;
            dv[1] = req_mon.delta_y;
            dv[2] = req_mon.delta_z;
            expected_results.push_back(predict_pair(req_mon.element_a, req_mon.element_b,
                                                    dv, req_mon.last_pair));
         end
      end
   end

endmodule

@@ test/tb_pairwise_dispersion_energy_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pairwise dispersion energy core testbench
// Drives atom pairs through bursty transfers against a stalling result side,
// in three phases with the gradient switch on, off and on again. A directed
// set covers element and delta extremes, bad elements and coincident atoms;
// random molecules follow. The checker beside the block does all comparing.
// ----------------------------------------------------------------------------
module tb_pairwise_dispersion_energy_core;

   localparam int CYCLE_LIMIT = 8000000;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic csr_write_data;
   int   fail_count;
   int   owed_count;
   int   result_count;
   int   cycle_count;
   int   pairs_sent;
   int   bad_pairs;
   int   molecules;
   int   burst_left;
   int   stall_mode;

   pde_req_if req_chan();
   pde_rsp_if rsp_chan();

   pairwise_dispersion_energy_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_chan         (req_chan.sink),
      .rsp_chan         (rsp_chan.source)
   );

   pde_pair_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_mon          (req_chan),
      .rsp_mon          (rsp_chan),
      .fail_count       (fail_count),
      .owed_count       (owed_count),
      .result_count     (result_count)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (cycle_count % 97 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: begin
            rsp_chan.ready = 1'b1;
         end
         1: begin
            rsp_chan.ready = 1'($urandom_range(0, 1));
         end
         2: begin
            rsp_chan.ready = (cycle_count % 5 == 0);
         end
         default: begin
            rsp_chan.ready = ($urandom_range(0, 9) == 0);
         end
      endcase
   end

   task automatic send_pair(input logic [5:0] za, input logic [5:0] zb,
                            input logic [31:0] dx, input logic [31:0] dy,
                            input logic [31:0] dz, input logic last);
      if (burst_left == 0) begin
         req_chan.valid = 1'b0;
         repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40)) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_chan.valid = 1'b1;
      req_chan.element_a = za;
      req_chan.element_b = zb;
      req_chan.delta_x = dx;
      req_chan.delta_y = dy;
      req_chan.delta_z = dz;
      req_chan.last_pair = last;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      pairs_sent++;
      if (za < 1 || za > pde_pkg::PDE_MAX_ELEMENT || zb < 1 ||
          zb > pde_pkg::PDE_MAX_ELEMENT) bad_pairs++;
      if (last) molecules++;
   endtask

   task automatic drain;
      req_chan.valid = 1'b0;
      burst_left = 0;
      while (owed_count != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_gradient_enable(input logic value);
      drain();
      csr_write_enable = 1'b1;
      csr_write_data = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   function automatic logic [31:0] random_delta();
      logic [31:0] v;
      case ($urandom_range(0, 9))
         0, 1: v = $urandom();
         2: v = $urandom_range(0, 4095);
         3: v = $urandom_range(0, 32'h0080_0000);
         default: v = $urandom_range(32'h0080_0000, 32'h0A00_0000);
      endcase
      if ($urandom_range(0, 1)) v = -v;
      return v;
   endfunction

   function automatic logic [5:0] random_element();
      if ($urandom_range(0, 99) < 88) return 6'($urandom_range(1, pde_pkg::PDE_MAX_ELEMENT));
      return $urandom_range(0, 1) ? 6'd0 :
             6'($urandom_range(pde_pkg::PDE_MAX_ELEMENT + 1, 63));
   endfunction

   task automatic random_pairs(input int count);
      logic [5:0] za;
      logic [5:0] zb;
      for (int i = 0; i < count; i++) begin
         za = random_element();
         zb = random_element();
         if ($urandom_range(0, 24) == 0)
            send_pair(za, zb, 32'd0, 32'd0, 32'd0, $urandom_range(0, 7) == 0);
         else
            send_pair(za, zb, random_delta(), random_delta(), random_delta(),
                      $urandom_range(0, 7) == 0);
      end
   endtask

   initial begin
      reset = 1'b1;
      cycle_count = 0;
      csr_write_enable = 1'b0;
      csr_write_data = 1'b0;
      req_chan.valid = 1'b0;
      req_chan.element_a = '0;
      req_chan.element_b = '0;
      req_chan.delta_x = '0;
      req_chan.delta_y = '0;
      req_chan.delta_z = '0;
      req_chan.last_pair = 1'b0;
      rsp_chan.ready = 1'b0;
      stall_mode = 0;
      pairs_sent = 0;
      bad_pairs = 0;
      molecules = 0;
      burst_left = 0;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      write_gradient_enable(1'b1);
      send_pair(6'd1, 6'd1, 32'h0200_0000, 32'd0, 32'd0, 1'b0);
      send_pair(6'd54, 6'd54, 32'd0, 32'hFE00_0000, 32'd0, 1'b0);
      send_pair(6'd1, 6'd54, 32'd0, 32'd0, 32'h7FFF_FFFF, 1'b0);
      send_pair(6'd54, 6'd1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
      send_pair(6'd6, 6'd8, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
      send_pair(6'd6, 6'd6, 32'd1, 32'd0, 32'd0, 1'b0);
      send_pair(6'd7, 6'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      send_pair(6'd8, 6'd1, 32'd0, 32'd0, 32'd0, 1'b1);
      send_pair(6'd0, 6'd6, 32'h0300_0000, 32'd0, 32'd0, 1'b0);
      send_pair(6'd6, 6'd55, 32'h0300_0000, 32'h0100_0000, 32'd0, 1'b0);
      send_pair(6'd63, 6'd63, 32'd0, 32'd0, 32'd0, 1'b0);
      send_pair(6'd17, 6'd35, 32'h0500_0000, 32'hFB00_0000, 32'h0200_0000, 1'b1);
      send_pair(6'd26, 6'd26, 32'h0040_0000, 32'h0040_0000, 32'h0040_0000, 1'b0);
      send_pair(6'd53, 6'd36, 32'h0AAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
      send_pair(6'd2, 6'd10, 32'h0600_0000, 32'h0600_0000, 32'd0, 1'b1);

      random_pairs(200);
      drain();
      random_pairs(200);
      write_gradient_enable(1'b0);
      send_pair(6'd54, 6'd54, 32'h0080_0000, 32'd0, 32'd0, 1'b0);
      send_pair(6'd1, 6'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 1'b1);
      random_pairs(200);
      write_gradient_enable(1'b1);
      random_pairs(230);
      drain();
      repeat (200) @(negedge clock);

      $display("Sent %0d pairs (%0d with bad elements) in %0d molecules; %0d results checked.",
               pairs_sent, bad_pairs, molecules, result_count);
      $display("Gradient switch covered on, off and on again.");
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
